@@ design/tpe_pkg.sv @@
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants for the tape pulse encoder with histogram.
// ----------------------------------------------------------------------------
package tpe_pkg;

    localparam int HIST_BINS = 256;
    localparam int HIST_AW   = $clog2(HIST_BINS);
    localparam int CNT_W     = 32;
    localparam int TICK_W    = 32;
    localparam int RATE_W    = 32;
    localparam int LEN_W     = 32;
    localparam int PROD_W    = LEN_W + RATE_W;
    localparam int FRAC_W    = 16;
    localparam int RND_W     = PROD_W - FRAC_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(32'h0001_0000);
    localparam logic [TICK_W-1:0] SHORT_MAX  = TICK_W'(255);
    localparam logic [15:0]       REM_SAT    = 16'h7FFF;

    localparam logic [1:0] FUNC_PULSE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    typedef struct packed {
        logic               rd_en;
        logic [HIST_AW-1:0] rd_addr;
        logic               wr_en;
        logic [HIST_AW-1:0] wr_addr;
        logic [CNT_W-1:0]   wr_data;
        logic               clr;
    } hist_req_t;

endpackage

@@ design/tpe_hist.sv @@
// ----------------------------------------------------------------------------
// tpe_hist
// Histogram counter memory with per-bin valid bits, registered read and
// forwarding of a write or clear that lands on the same edge as a read.
// ----------------------------------------------------------------------------
module tpe_hist
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  tpe_pkg::hist_req_t                  req,
    output logic [tpe_pkg::CNT_W-1:0]           rd_data
);
    import tpe_pkg::*;

    logic [CNT_W-1:0]     mem [HIST_BINS];
    logic [CNT_W-1:0]     mem_q_reg;
    logic [HIST_BINS-1:0] vld_reg;
    logic                 vld_q_reg;
    logic                 fwd_wr_reg;
    logic                 fwd_clr_reg;
    logic [CNT_W-1:0]     fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg    <= mem[req.rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            vld_q_reg   <= 1'b0;
            fwd_wr_reg  <= 1'b0;
            fwd_clr_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_q_reg   <= vld_reg[req.rd_addr];
                fwd_wr_reg  <= req.wr_en && (req.wr_addr == req.rd_addr);
                fwd_clr_reg <= req.clr;
            end
        end
    end

    always_comb
    begin
        priority if (fwd_wr_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (fwd_clr_reg || !vld_q_reg)
        begin
            rd_data = '0;
        end
        else
        begin
            rd_data = mem_q_reg;
        end
    end

endmodule

@@ design/tape_pulse_encoder_histogram_core.sv @@
// ----------------------------------------------------------------------------
// tape_pulse_encoder_histogram_core
// Scales pulse lengths to tape ticks, emits tape bytes and keeps a
// pulse-length histogram plus a running tick total.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, func, length_units,         in
//            bin_index
//   out      out_valid/out_ready, out_byte, last,           out
//            remainder_q16, bin_count, total_ticks
//   cfg      cfg_valid/cfg_ready, cfg_data (tick_rate_q16)  in
//
// The input transfer loads the capture stage; multiply, round with histogram
// read, and update into the output register follow as registered stages.
// One item per cycle is sustained while out_ready is high and each item gives
// one result; a long tick count holds the output register for 4 or 8 results.
// Reset clears the histogram valid bits at once; no clearing pass is needed.
// A stall on the output backs up the stages in order; cfg_ready is always high.
// ----------------------------------------------------------------------------
module tape_pulse_encoder_histogram_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [tpe_pkg::LEN_W-1:0]     length_units,
    input  logic [7:0]                    bin_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_byte,
    output logic                          last,
    output logic signed [15:0]            remainder_q16,
    output logic [31:0]                   bin_count,
    output logic [31:0]                   total_ticks,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpe_pkg::RATE_W-1:0]    cfg_data
);
    import tpe_pkg::*;

    logic [RATE_W-1:0]  rate_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_func_reg;
    logic [LEN_W-1:0]   s1_len_reg;
    logic [HIST_AW-1:0] s1_idx_reg;

    logic               s2_valid_reg;
    logic [1:0]         s2_func_reg;
    logic [PROD_W-1:0]  s2_prod_reg;
    logic [HIST_AW-1:0] s2_idx_reg;

    logic               s3_valid_reg;
    logic [1:0]         s3_func_reg;
    logic [TICK_W-1:0]  s3_ticks_reg;
    logic [15:0]        s3_rem_reg;
    logic [HIST_AW-1:0] s3_addr_reg;

    logic               e_valid_reg;
    logic               e_pulse_reg;
    logic [2:0]         e_cnt_reg;
    logic [2:0]         e_lastidx_reg;
    logic [TICK_W-1:0]  e_ticks_reg;
    logic [15:0]        e_rem_reg;
    logic [31:0]        e_bin_reg;
    logic [31:0]        e_total_reg;

    logic [TICK_W-1:0]  total_reg;
    logic [TICK_W-1:0]  total_next;

    logic               s1_go;
    logic               s2_go;
    logic               s3_ready;
    logic               e_free;
    logic               e_load;
    logic               out_fire;

    logic [RND_W-1:0]   rnd;
    logic               sat;
    logic [TICK_W-1:0]  ticks_next;
    logic [15:0]        rem_next;
    logic [HIST_AW-1:0] addr_next;

    hist_req_t          hreq;
    logic [CNT_W-1:0]   hdata;
    logic [2:0]         lastidx_next;

    assign cfg_ready = 1'b1;

    assign last     = (e_cnt_reg == e_lastidx_reg);
    assign out_valid = e_valid_reg;
    assign out_fire  = out_valid && out_ready;
    assign e_free    = !e_valid_reg || (out_ready && last);
    assign e_load    = s3_valid_reg && e_free;
    assign s3_ready  = !s3_valid_reg || e_free;
    assign s2_go     = s2_valid_reg && s3_ready;
    assign s1_go     = s1_valid_reg && (!s2_valid_reg || s3_ready);
    assign in_ready  = !s1_valid_reg || !s2_valid_reg || s3_ready;

    // round half up, saturate at the tick width
    assign rnd        = s2_prod_reg[PROD_W-1:FRAC_W] + RND_W'(s2_prod_reg[FRAC_W-1]);
    assign sat        = |rnd[RND_W-1:TICK_W];
    assign ticks_next = sat ? '1 : rnd[TICK_W-1:0];
    assign rem_next   = sat ? REM_SAT : s2_prod_reg[FRAC_W-1:0];

    always_comb
    begin
        if (s2_func_reg == FUNC_READ)
        begin
            addr_next = s2_idx_reg;
        end
        else if (ticks_next > SHORT_MAX)
        begin
            addr_next = '0;
        end
        else
        begin
            addr_next = ticks_next[HIST_AW-1:0];
        end
    end

    always_comb
    begin
        hreq.rd_en   = s2_go;
        hreq.rd_addr = addr_next;
        hreq.wr_en   = e_load && (s3_func_reg == FUNC_PULSE);
        hreq.wr_addr = s3_addr_reg;
        hreq.wr_data = hdata + CNT_W'(1);
        hreq.clr     = e_load && (s3_func_reg == FUNC_CLEAR);
    end

    tpe_hist u_hist
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (hreq),
        .rd_data (hdata)
    );

    always_comb
    begin
        unique case (s3_func_reg)
            FUNC_PULSE: total_next = total_reg + s3_ticks_reg;
            FUNC_CLEAR: total_next = '0;
            FUNC_READ:  total_next = total_reg;
            FUNC_NONE:  total_next = total_reg;
        endcase
    end

    always_comb
    begin
        if (s3_func_reg != FUNC_PULSE || s3_ticks_reg <= SHORT_MAX)
        begin
            lastidx_next = 3'd0;
        end
        else if (s3_ticks_reg[31:24] != 8'd0)
        begin
            lastidx_next = 3'd7;
        end
        else
        begin
            lastidx_next = 3'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_RESET;
            total_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
            e_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rate_reg <= cfg_data;
            end
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= (func != FUNC_NONE);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (e_load)
            begin
                s3_valid_reg <= 1'b0;
            end
            if (e_load)
            begin
                total_reg   <= total_next;
                e_valid_reg <= 1'b1;
                e_cnt_reg   <= '0;
            end
            else if (out_fire)
            begin
                if (last)
                begin
                    e_valid_reg <= 1'b0;
                end
                else
                begin
                    e_cnt_reg <= e_cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg <= func;
            s1_len_reg  <= length_units;
            s1_idx_reg  <= bin_index[HIST_AW-1:0];
        end
        if (s1_go)
        begin
            s2_func_reg <= s1_func_reg;
            s2_prod_reg <= PROD_W'(s1_len_reg) * PROD_W'(rate_reg);
            s2_idx_reg  <= s1_idx_reg;
        end
        if (s2_go)
        begin
            s3_func_reg  <= s2_func_reg;
            s3_ticks_reg <= ticks_next;
            s3_rem_reg   <= rem_next;
            s3_addr_reg  <= addr_next;
        end
        if (e_load)
        begin
            e_pulse_reg   <= (s3_func_reg == FUNC_PULSE);
            e_lastidx_reg <= lastidx_next;
            e_ticks_reg   <= s3_ticks_reg;
            e_rem_reg     <= s3_rem_reg;
            e_bin_reg     <= (s3_func_reg == FUNC_READ) ? 32'(hdata) : 32'd0;
            e_total_reg   <= 32'(total_next);
        end
    end

    always_comb
    begin
        if (!e_pulse_reg)
        begin
            out_byte = 8'd0;
        end
        else if (e_lastidx_reg == 3'd0)
        begin
            out_byte = e_ticks_reg[7:0];
        end
        else
        begin
            unique case (e_cnt_reg)
                3'd1:    out_byte = e_ticks_reg[7:0];
                3'd2:    out_byte = e_ticks_reg[15:8];
                3'd3:    out_byte = e_ticks_reg[23:16];
                3'd5:    out_byte = e_ticks_reg[31:24];
                default: out_byte = 8'd0;
            endcase
        end
    end

    assign remainder_q16 = (last && e_pulse_reg) ? $signed(e_rem_reg) : 16'sd0;
    assign bin_count     = e_bin_reg;
    assign total_ticks   = e_total_reg;

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        e_valid_reg |-> (e_cnt_reg <= e_lastidx_reg))
        else $error("result index past last result");

    a_multi_only_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (e_valid_reg && !last) |-> e_pulse_reg)
        else $error("multi-result item is not a pulse");

    a_wr_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(hreq.wr_en && hreq.clr))
        else $error("histogram write and clear on the same edge");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !e_free) |=> (s3_valid_reg && $stable(s3_ticks_reg)
                                       && $stable(s3_addr_reg)))
        else $error("stalled update stage lost its item");

    a_read_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        hreq.rd_en |-> (s2_valid_reg && (!s3_valid_reg || e_load)))
        else $error("histogram read without a stage transfer");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for tape_pulse_encoder_histogram_core. A directed run covers the
// length and rate extremes, long counts of four and eight bytes, rounding
// ties, saturation, zero rate, the unused selector, reads and clears. It is
// followed by random phases under several tick rates. The tick rate is
// written between phases. Results are predicted per transfer and checked
// field by field. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;

    import tpe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 16;

    typedef struct packed {
        logic [1:0]  sel;
        logic [31:0] len;
        logic [7:0]  idx;
    } tape_cmd_t;

    typedef struct packed {
        logic [7:0]         tape_byte;
        logic               is_last;
        logic signed [15:0] rem_q16;
        logic [31:0]        bin_cnt;
        logic [31:0]        total;
    } tape_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_NONE;
    logic [31:0] length_units = '0;
    logic [7:0]  bin_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic signed [15:0] remainder_q16;
    logic [31:0] bin_count;
    logic [31:0] total_ticks;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    tape_cmd_t   cmd_q [$];
    tape_word_t  tape_out_q [$];

    logic [31:0] pulse_hist [HIST_BINS];
    logic [31:0] tick_sum = '0;
    logic [31:0] tick_rate = RATE_RESET;

    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    logic        in_idle_on = 1'b0;
    logic        out_idle_on = 1'b0;
    logic [1:0]  in_gap = '0;
    logic [1:0]  out_wait = '0;
    int          quiet_cycles = 0;
    int          mismatch_count = 0;

    tape_pulse_encoder_histogram_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .length_units  (length_units),
        .bin_index     (bin_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last          (last),
        .remainder_q16 (remainder_q16),
        .bin_count     (bin_count),
        .total_ticks   (total_ticks),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        foreach (pulse_hist[i])
            pulse_hist[i] = '0;
    end

    task automatic flag_mismatch(input string what, input longint got,
                                 input longint want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic encode_item(input logic [1:0] sel, input logic [31:0] len,
                               input logic [7:0] idx);
        logic [63:0] prod;
        logic [63:0] rounded;
        logic [31:0] ticks;
        logic [31:0] rest;
        logic [15:0] rem;
        logic [7:0]  bin;
        tape_word_t  words [8];
        tape_word_t  w;
        int          n;
        w = '0;
        n = 0;
        if (sel == FUNC_READ)
        begin
            w.is_last = 1'b1;
            w.bin_cnt = pulse_hist[idx];
            w.total   = tick_sum;
            tape_out_q.push_back(w);
        end
        else if (sel == FUNC_CLEAR)
        begin
            foreach (pulse_hist[i])
                pulse_hist[i] = '0;
            tick_sum  = '0;
            w.is_last = 1'b1;
            tape_out_q.push_back(w);
        end
        else if (sel == FUNC_PULSE)
        begin
            prod    = 64'(len) * 64'(tick_rate);
            rounded = (prod + 64'h8000) >> 16;
            if (rounded > 64'hFFFF_FFFF)
            begin
                ticks = '1;
                rem   = REM_SAT;
            end
            else
            begin
                ticks = rounded[31:0];
                rem   = 16'(prod - (rounded << 16));
            end
            tick_sum = tick_sum + ticks;
            w.total  = tick_sum;
            if (ticks > SHORT_MAX)
            begin
                rest = ticks;
                do
                begin
                    w.tape_byte = 8'h00;
                    words[n] = w;
                    n = n + 1;
                    for (int k = 0; k < 3; k++)
                    begin
                        w.tape_byte = rest[7:0];
                        words[n] = w;
                        n = n + 1;
                        rest = rest >> 8;
                    end
                end
                while (rest != 0);
                bin = 8'd0;
            end
            else
            begin
                w.tape_byte = ticks[7:0];
                words[n] = w;
                n = n + 1;
                bin = ticks[7:0];
            end
            pulse_hist[bin] = pulse_hist[bin] + 32'd1;
            words[n-1].is_last = 1'b1;
            words[n-1].rem_q16 = rem;
            for (int k = 0; k < n; k++)
                tape_out_q.push_back(words[k]);
        end
    endtask

    always @(posedge clk)
    begin : watch
        tape_word_t w;
        in_taken  <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (out_valid && out_ready)
        begin
            if (tape_out_q.size() == 0)
                flag_mismatch("result with nothing pending", out_byte, 0);
            else
            begin
                w = tape_out_q.pop_front();
                if (out_byte !== w.tape_byte)
                    flag_mismatch("out_byte", out_byte, w.tape_byte);
                if (last !== w.is_last)
                    flag_mismatch("last", last, w.is_last);
                if (remainder_q16 !== w.rem_q16)
                    flag_mismatch("remainder_q16", remainder_q16, w.rem_q16);
                if (bin_count !== w.bin_cnt)
                    flag_mismatch("bin_count", bin_count, w.bin_cnt);
                if (total_ticks !== w.total)
                    flag_mismatch("total_ticks", total_ticks, w.total);
            end
        end
        if (cfg_valid && cfg_ready)
            tick_rate = cfg_data;
        if (in_valid && in_ready)
            encode_item(func, length_units, bin_index);
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
    begin : drive_in
        tape_cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= '0;
        end
        else if (in_valid && !in_taken)
        begin
            in_valid <= 1'b1;
        end
        else if (in_gap != 0)
        begin
            in_valid <= 1'b0;
            in_gap   <= in_gap - 2'd1;
        end
        else if (cmd_q.size() != 0)
        begin
            c = cmd_q.pop_front();
            func         <= c.sel;
            length_units <= c.len;
            bin_index    <= c.idx;
            in_valid     <= 1'b1;
            in_gap       <= in_idle_on ? 2'($urandom_range(0, 3)) : 2'd0;
        end
        else
            in_valid <= 1'b0;
    end

    always @(negedge clk)
    begin : drive_out
        logic [1:0] w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait  <= '0;
        end
        else if (out_wait != 0)
        begin
            out_ready <= 1'b0;
            out_wait  <= out_wait - 2'd1;
        end
        else if (out_taken && out_idle_on)
        begin
            w = 2'($urandom_range(0, 3));
            if (w == 0)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                out_wait  <= w - 2'd1;
            end
        end
        else
            out_ready <= 1'b1;
    end

    task automatic add_cmd(input logic [1:0] sel, input logic [31:0] len,
                           input logic [7:0] idx);
        tape_cmd_t c;
        c.sel = sel;
        c.len = len;
        c.idx = idx;
        cmd_q.push_back(c);
    endtask

    task automatic add_random(input int count);
        int          made;
        int          r;
        logic [1:0]  sel;
        logic [7:0]  idx;
        made = 0;
        while (made < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
                sel = FUNC_PULSE;
            else if (r < 85)
                sel = FUNC_READ;
            else if (r < 92)
                sel = FUNC_CLEAR;
            else
                sel = FUNC_NONE;
            idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            add_cmd(sel, $urandom >> $urandom_range(0, 31), idx);
            if (sel != FUNC_NONE)
                made++;
        end
    endtask

    task automatic drain();
        while (cmd_q.size() != 0 || in_valid || tape_out_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tick_rate(input logic [31:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] rate_plan [6];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_cmd(FUNC_READ,  32'd0,          8'd0);
        add_cmd(FUNC_READ,  32'd0,          8'hFF);
        add_cmd(FUNC_PULSE, 32'd0,          8'd0);
        add_cmd(FUNC_PULSE, 32'd1,          8'd0);
        add_cmd(FUNC_PULSE, 32'd255,        8'd0);
        add_cmd(FUNC_PULSE, 32'd256,        8'd0);
        add_cmd(FUNC_PULSE, 32'h0100_0000,  8'd0);
        add_cmd(FUNC_PULSE, 32'hFFFF_FFFF,  8'hFF);
        add_cmd(FUNC_NONE,  32'hFFFF_FFFF,  8'hFF);
        add_cmd(FUNC_READ,  32'hFFFF_FFFF,  8'd0);
        add_cmd(FUNC_READ,  32'd0,          8'd1);
        add_cmd(FUNC_READ,  32'd0,          8'hFF);
        add_cmd(FUNC_CLEAR, 32'hFFFF_FFFF,  8'hFF);
        add_cmd(FUNC_READ,  32'd0,          8'd0);
        drain();

        write_tick_rate(32'd1);
        add_cmd(FUNC_PULSE, 32'h0000_7FFF,  8'd0);
        add_cmd(FUNC_PULSE, 32'h0000_8000,  8'd0);
        add_cmd(FUNC_PULSE, 32'hFFFF_FFFF,  8'd0);
        drain();

        write_tick_rate(32'd0);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        add_cmd(FUNC_PULSE, 32'hFFFF_FFFF,  8'd0);
        add_cmd(FUNC_PULSE, 32'd1,          8'd0);
        drain();

        write_tick_rate(32'hFFFF_FFFF);
        add_cmd(FUNC_PULSE, 32'd1,          8'd0);
        add_cmd(FUNC_PULSE, 32'h0001_0000,  8'd0);
        add_cmd(FUNC_PULSE, 32'h0001_0001,  8'd0);
        add_cmd(FUNC_PULSE, 32'hFFFF_FFFF,  8'd0);
        add_cmd(FUNC_READ,  32'd0,          8'd0);
        drain();

        rate_plan = '{RATE_RESET, 32'hFFFF_FFFF, 32'd1, 32'h0000_8000, 32'd0, 32'd0};
        rate_plan[4] = $urandom;
        rate_plan[5] = $urandom_range(32'h100, 32'h40000);
        for (int p = 0; p < 6; p++)
        begin
            write_tick_rate(rate_plan[p]);
            in_idle_on  = p[0];
            out_idle_on = p[1];
            add_random(PHASE_ITEMS);
            drain();
        end

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
design/tpe_pkg.sv
design/tpe_hist.sv
design/tape_pulse_encoder_histogram_core.sv
test/tb.sv
